FILE: sv/drks_pkg.sv
// -----------------------------------------------------------------------------
// drks_pkg : shared types and constants for the digit-remap key sorter
// Field widths, divide-by-ten constants, digit map helpers, cell and stage links.
// -----------------------------------------------------------------------------
package drks_pkg;

    localparam int VAL_W    = 30;
    localparam int KEY_W    = 30;
    localparam int MAP_W    = 40;
    localparam int NIB_W    = 4;
    localparam int DIGIT_MAX = 9;

    localparam logic [MAP_W-1:0] MAP_RESET = 40'h98_7654_3210;

    // floor(v / 10) == (v * DIV10_MAGIC) >> DIV10_SHIFT for any v below 2**32
    localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;
    localparam int          PROD_W      = VAL_W + 32;

    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } t_state;

    // one transaction in flight through the key pipeline
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [VAL_W-1:0] rem;     // digits not yet mapped
        logic [VAL_W-1:0] number;  // original value
        logic [KEY_W-1:0] key;     // partial key
    } t_stage;

    // what a sort cell shows its neighbours
    typedef struct packed {
        logic             valid;
        logic             gt;      // held key above the broadcast key
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] number;
    } t_cell;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] number;
    } t_item;

    function automatic logic [KEY_W-1:0] pow10(input int n);
        logic [KEY_W-1:0] p;
        p = KEY_W'(1);
        for (int k = 0; k < n; k++) begin
            p = KEY_W'(p * KEY_W'(10));
        end
        return p;
    endfunction

    // entries above nine saturate at nine
    function automatic logic [NIB_W-1:0] map_digit(input logic [MAP_W-1:0] map,
                                                   input logic [NIB_W-1:0] d);
        logic [NIB_W-1:0] dd;
        logic [NIB_W-1:0] e;
        dd = (d > NIB_W'(DIGIT_MAX)) ? NIB_W'(DIGIT_MAX) : d;
        e  = map[{dd, 2'b00} +: NIB_W];
        return (e > NIB_W'(DIGIT_MAX)) ? NIB_W'(DIGIT_MAX) : e;
    endfunction

endpackage

FILE: sv/digit_remap_key_sorter.sv
// -----------------------------------------------------------------------------
// digit_remap_key_sorter : stable sort of a set of numbers by digit-mapped key
// Key pipeline of DIGITS stages feeding a chain of MAX_ITEMS insertion cells.
// -----------------------------------------------------------------------------
// Use: numbers arrive on the slave stream, one per transaction, the final one
// of a set with tlast. Each number's key is its decimal digits passed through
// the digit map (written on i_cfg_we while idle; the block does not enforce
// this). The key pipeline has one registered stage per decimal place, then the
// number drops into the cell chain. Throughput while filling: one transaction
// per cycle. Once the tlast transaction is taken, the slave stream stalls
// until the set has drained; it passes through the DIGITS stages into the
// cells, and the first result is valid straight after it enters them. Results
// leave from the head cell, one per cycle while the master is ready, lowest key
// first, equal keys in arrival order, tlast on the final one. The slave stream
// is ready again the cycle after the final result transaction.
// A set beyond MAX_ITEMS numbers loses the extra numbers.
// A master-side stall simply holds the head cell; nothing is lost.
// Reset empties the cells and pipeline and restores the identity digit map.
// -----------------------------------------------------------------------------
module digit_remap_key_sorter #(
    parameter int MAX_ITEMS = 64,
    parameter int DIGITS    = 9
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [29:0] item_value, [31:30] zero
    input  logic        i_s_tlast,   // last_item
    // master stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [29:0] sorted_value, [31:30] zero
    output logic        o_m_tlast,   // last_result
    // digit map register
    input  logic        i_cfg_we,
    input  logic [39:0] i_cfg_wdata  // nibble d: replacement for decimal digit d
);
    import drks_pkg::*;

    logic [MAP_W-1:0] r_map;
    logic             r_pend;     // a tlast transaction has been taken
    logic             n_pend;
    t_state           r_state;
    t_state           n_state;

    t_stage w_stage [DIGITS+1];
    t_cell  w_cell  [MAX_ITEMS];
    t_item  w_new;

    logic w_s_acc;
    logic w_ins;
    logic w_last_in;
    logic w_full;
    logic w_shift;
    logic w_out_last;

    // digit map register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= MAP_RESET;
        end else if (i_cfg_we) begin
            r_map <= i_cfg_wdata;
        end
    end

    // ---- key pipeline: one decimal place per stage ----
    assign w_s_acc = i_s_tvalid && o_s_tready;

    always_comb begin
        w_stage[0].valid  = w_s_acc;
        w_stage[0].last   = i_s_tlast;
        w_stage[0].rem    = i_s_tdata[VAL_W-1:0];
        w_stage[0].number = i_s_tdata[VAL_W-1:0];
        w_stage[0].key    = '0;
    end

    for (genvar g = 0; g < DIGITS; g++) begin : g_stage
        drks_key_stage #(
            .STAGE (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_map   (r_map),
            .i_stage (w_stage[g]),
            .o_stage (w_stage[g+1])
        );
    end

    // ---- insertion chain ----
    assign w_full    = w_cell[MAX_ITEMS-1].valid;
    assign w_ins     = w_stage[DIGITS].valid && !w_full;
    assign w_last_in = w_stage[DIGITS].valid && w_stage[DIGITS].last;
    assign w_new.key    = w_stage[DIGITS].key;
    assign w_new.number = w_stage[DIGITS].number;

    for (genvar c = 0; c < MAX_ITEMS; c++) begin : g_cell
        t_cell w_prev;
        t_cell w_next;

        if (c == 0) begin : g_head
            // head cell takes a new item when it is empty or its own key is above it
            assign w_prev = '{valid: 1'b1, gt: 1'b0, key: '0, number: '0};
        end else begin : g_body
            assign w_prev = w_cell[c-1];
        end

        if (c == MAX_ITEMS - 1) begin : g_tail
            assign w_next = '{valid: 1'b0, gt: 1'b0, key: '0, number: '0};
        end else begin : g_inner
            assign w_next = w_cell[c+1];
        end

        drks_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ins   (w_ins),
            .i_shift (w_shift),
            .i_new   (w_new),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_cell  (w_cell[c])
        );
    end

    // ---- control ----
    assign w_out_last = !w_cell[1].valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_FILL: begin
                if (w_last_in) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_shift && w_out_last) begin
                    n_state = ST_FILL;
                end
            end
            default: n_state = ST_FILL;
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        case (r_state)
            ST_FILL: begin
                o_s_tready = !r_pend;
            end
            ST_DRAIN: begin
                o_m_tvalid = w_cell[0].valid;
            end
            default: begin
                o_s_tready = 1'b0;
                o_m_tvalid = 1'b0;
            end
        endcase
    end

    assign w_shift = o_m_tvalid && i_m_tready;

    always_comb begin
        n_pend = r_pend;
        if (w_s_acc && i_s_tlast) begin
            n_pend = 1'b1;
        end else if (w_shift && w_out_last) begin
            n_pend = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    assign o_m_tdata = {2'b00, w_cell[0].number};
    assign o_m_tlast = w_out_last;

endmodule

FILE: sv/drks_key_stage.sv
// -----------------------------------------------------------------------------
// drks_key_stage : one decimal place of the key pipeline
// Splits off the low decimal digit, maps it and adds it at this stage's place.
// -----------------------------------------------------------------------------
module drks_key_stage #(
    parameter int STAGE = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [drks_pkg::MAP_W-1:0] i_map,
    input  drks_pkg::t_stage          i_stage,
    output drks_pkg::t_stage          o_stage
);
    import drks_pkg::*;

    localparam logic [KEY_W-1:0] PLACE = pow10(STAGE);

    logic [PROD_W-1:0] w_prod;
    logic [VAL_W-1:0]  w_quot;
    logic [VAL_W-1:0]  w_rem10;
    logic [NIB_W-1:0]  w_digit;
    logic [NIB_W-1:0]  w_mapped;
    logic [KEY_W-1:0]  w_term;
    logic              w_use;
    t_stage            r_stage;
    t_stage            n_stage;

    assign w_prod   = PROD_W'(i_stage.rem) * PROD_W'(DIV10_MAGIC);
    assign w_quot   = VAL_W'(w_prod >> DIV10_SHIFT);
    assign w_rem10  = i_stage.rem - ((w_quot << 3) + (w_quot << 1));
    assign w_digit  = w_rem10[NIB_W-1:0];
    assign w_mapped = map_digit(i_map, w_digit);
    assign w_term   = KEY_W'(PLACE * KEY_W'(w_mapped));
    // leading zeros are skipped; only the number zero maps its digit 0
    assign w_use    = (i_stage.rem != '0) || (STAGE == 0);

    always_comb begin
        n_stage      = i_stage;
        n_stage.rem  = w_quot;
        n_stage.key  = w_use ? (i_stage.key + w_term) : i_stage.key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage.valid <= n_stage.valid;
        end
        r_stage.last   <= n_stage.last;
        r_stage.rem    <= n_stage.rem;
        r_stage.number <= n_stage.number;
        r_stage.key    <= n_stage.key;
    end

    assign o_stage = r_stage;

endmodule

FILE: sv/drks_cell.sv
// -----------------------------------------------------------------------------
// drks_cell : one insertion cell of the sorting chain
// Holds one key/number pair; shifts up on insertion, down on drain.
// -----------------------------------------------------------------------------
module drks_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_ins,
    input  logic           i_shift,
    input  drks_pkg::t_item i_new,
    input  drks_pkg::t_cell i_prev,
    input  drks_pkg::t_cell i_next,
    output drks_pkg::t_cell o_cell
);
    import drks_pkg::*;

    logic             r_valid;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_number;
    logic             n_valid;
    logic [KEY_W-1:0] n_key;
    logic [VAL_W-1:0] n_number;
    logic             w_gt;
    logic             w_take_new;

    // strict compare keeps arrival order among equal keys
    assign w_gt       = r_valid && (r_key > i_new.key);
    assign w_take_new = (w_gt || !r_valid) && i_prev.valid && !i_prev.gt;

    always_comb begin
        n_valid  = r_valid;
        n_key    = r_key;
        n_number = r_number;
        if (i_shift) begin
            n_valid  = i_next.valid;
            n_key    = i_next.key;
            n_number = i_next.number;
        end else if (i_ins) begin
            if (i_prev.gt) begin
                n_valid  = i_prev.valid;
                n_key    = i_prev.key;
                n_number = i_prev.number;
            end else if (w_take_new) begin
                n_valid  = 1'b1;
                n_key    = i_new.key;
                n_number = i_new.number;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_key    <= n_key;
        r_number <= n_number;
    end

    assign o_cell.valid  = r_valid;
    assign o_cell.gt     = w_gt;
    assign o_cell.key    = r_key;
    assign o_cell.number = r_number;

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// testbench : self-checking bench for the digit-remap key sorter
// Sends sets of numbers on the slave stream and predicts the stable,
// key-ordered run on the master stream under several digit maps and idle
// patterns. Covers oversized numbers, saturating map entries and full sets.
// -----------------------------------------------------------------------------
module testbench;
    import drks_pkg::*;

    localparam int MAX_ITEMS     = 64;
    localparam int DIGITS        = 9;
    localparam int RADIX         = 10;
    localparam int CLK_HALF      = 4;          // 8 ns period
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = DIGITS + 8; // key pipeline plus head cell, with margin
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 125;
    localparam int REPORT_MAX    = 10;

    typedef enum {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    // -------------------------------------------------------------------------
    // Expected-run store: keeps the current set ordered by mapped key (stable)
    // and queues the run that a last_item transaction releases.
    // -------------------------------------------------------------------------
    class sorted_run_checker;
        logic [MAP_W-1:0] digit_map;
        logic [KEY_W-1:0] set_key[MAX_ITEMS];
        logic [VAL_W-1:0] set_number[MAX_ITEMS];
        int               set_size;
        logic [VAL_W-1:0] due_value[$];
        bit               due_last[$];
        int               errors;

        function new();
            digit_map = MAP_RESET;
            set_size  = 0;
            errors    = 0;
        endfunction

        // map entries above nine count as nine
        function logic [NIB_W-1:0] remap(input int d);
            logic [NIB_W-1:0] e;
            e = digit_map[NIB_W*d +: NIB_W];
            return (e > NIB_W'(DIGIT_MAX)) ? NIB_W'(DIGIT_MAX) : e;
        endfunction

        // only the low DIGITS places are mapped; zero itself takes entry 0
        function logic [KEY_W-1:0] mapped_key(input logic [VAL_W-1:0] v);
            logic [KEY_W-1:0] key;
            logic [KEY_W-1:0] place;
            logic [VAL_W-1:0] rest;
            int               n;
            if (v == '0) begin
                return KEY_W'(remap(0));
            end
            key   = '0;
            place = KEY_W'(1);
            rest  = v;
            for (n = 0; n < DIGITS && rest != '0; n++) begin
                key   = key + KEY_W'(remap(int'(rest % RADIX)) * place);
                rest  = VAL_W'(rest / RADIX);
                place = KEY_W'(place * RADIX);
            end
            return key;
        endfunction

        function void note_number(input logic [VAL_W-1:0] v, input bit last_item);
            logic [KEY_W-1:0] key;
            int               pos;
            int               i;
            // a full set drops the number, but a last flag still releases the run
            if (set_size < MAX_ITEMS) begin
                key = mapped_key(v);
                pos = set_size;
                while (pos > 0 && set_key[pos-1] > key) begin
                    set_key[pos]    = set_key[pos-1];
                    set_number[pos] = set_number[pos-1];
                    pos--;
                end
                set_key[pos]    = key;
                set_number[pos] = v;
                set_size++;
            end
            if (last_item) begin
                for (i = 0; i < set_size; i++) begin
                    due_value.push_back(set_number[i]);
                    due_last.push_back(i == set_size - 1);
                end
                set_size = 0;
            end
        endfunction

        function void check_output(input logic [VAL_W-1:0] v, input logic last_result);
            logic [VAL_W-1:0] exp_value;
            bit               exp_last;
            if (due_value.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("ERROR: result with nothing expected: value %0d last %0b",
                             v, last_result);
                return;
            end
            exp_value = due_value.pop_front();
            exp_last  = due_last.pop_front();
            if (v !== exp_value || last_result !== exp_last) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("ERROR: expected value %0d last %0b, got value %0d last %0b",
                             exp_value, exp_last, v, last_result);
            end
        endfunction

        function int pending();
            return due_value.size();
        endfunction
    endclass

    // -------------------------------------------------------------------------
    // Signals
    // -------------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;    // [29:0] item_value, [31:30] zero
    logic        i_s_tlast;    // last_item
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;    // [29:0] sorted_value, [31:30] zero
    logic        o_m_tlast;    // last_result
    logic        i_cfg_we;
    logic [39:0] i_cfg_wdata;  // nibble d: replacement for decimal digit d

    sorted_run_checker runs;
    t_idle_mode        idle_mode = IDLE_NONE;
    int                cycle_count = 0;

    digit_remap_key_sorter #(
        .MAX_ITEMS (MAX_ITEMS),
        .DIGITS    (DIGITS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // run guard: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // -------------------------------------------------------------------------
    // Idle patterns: an idle chance of 84 percent for a single idling side, 13 when both do
    // -------------------------------------------------------------------------
    function automatic bit sender_waits();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(0, 99) < 84;
            IDLE_BOTH:   return $urandom_range(0, 99) < 13;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode)
            IDLE_RECEIVER: return $urandom_range(0, 99) < 84;
            IDLE_BOTH:     return $urandom_range(0, 99) < 13;
            default:       return 1'b0;
        endcase
    endfunction

    // master-side ready changes on the falling edge only
    always @(negedge i_clk) begin
        i_m_tready = !receiver_stalls();
    end

    // every master transaction is checked against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            runs.check_output(o_m_tdata[VAL_W-1:0], o_m_tlast);
    end

    // -------------------------------------------------------------------------
    // Slave-side driver: present one number, hold it until the transaction
    // completes on a rising edge, then note it in the expected-run store.
    // Returns just after that rising edge with tvalid still high.
    // -------------------------------------------------------------------------
    task automatic send_item(input logic [VAL_W-1:0] value, input bit last_item);
        @(negedge i_clk);
        while (sender_waits()) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = 32'(value);
        i_s_tlast  = last_item;
        forever begin
            @(posedge i_clk);
            if (o_s_tready)
                break;
        end
        runs.note_number(value, last_item);
    endtask

    // drop tvalid, let the run drain, then give the key pipeline time to empty
    task automatic drain_and_settle();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (runs.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // only called with the block idle
    task automatic write_digit_map(input logic [MAP_W-1:0] map);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = map;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        runs.digit_map = map;
    endtask

    // -------------------------------------------------------------------------
    // Stimulus
    // -------------------------------------------------------------------------
    initial begin
        int               p;
        int               k;
        int               sent;
        int               set_len;
        int               pick;
        logic [MAP_W-1:0] map;
        logic [VAL_W-1:0] value;

        runs        = new();
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tlast   = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed set under the identity map after reset: zero, all-ones,
        // ten-digit numbers whose high digit is ignored (equal keys with
        // short numbers, so arrival order must hold), trailing zeros.
        send_item(30'd5, 1'b0);
        send_item(30'd1000000005, 1'b0);
        send_item(30'd0, 1'b0);
        send_item(30'd1000000000, 1'b0);
        send_item({VAL_W{1'b1}}, 1'b0);
        send_item(30'd999999999, 1'b0);
        send_item(30'd100, 1'b0);
        send_item(30'd10, 1'b0);
        send_item(30'd1, 1'b0);
        send_item(30'd1, 1'b1);
        drain_and_settle();

        // Map with entries above nine (digits 2, 3, 9) and a non-zero entry
        // for digit 0, so the number zero keys to 7 and ties with 10.
        write_digit_map(40'hC5_1233_FA07);
        send_item(30'd0, 1'b0);
        send_item(30'd7, 1'b0);
        send_item(30'd1, 1'b0);
        send_item(30'd2, 1'b0);
        send_item(30'd3, 1'b0);
        send_item(30'd9, 1'b0);
        send_item(30'd45, 1'b0);
        send_item(30'd54, 1'b0);
        send_item({VAL_W{1'b1}}, 1'b0);
        send_item(30'd10, 1'b1);

        // Random phases, one idle pattern and one digit map each. The first set
        // of every phase sits around the capacity, so full sets drop numbers
        // and a dropped number can carry the last flag.
        for (p = 0; p < 4; p++) begin
            drain_and_settle();
            case (p)
                0: map = MAP_W'({$urandom, $urandom});
                1: map = '0;
                2: map = '1;
                default: begin
                    for (k = 0; k < 10; k++)
                        map[NIB_W*k +: NIB_W] = NIB_W'($urandom_range(0, DIGIT_MAX));
                end
            endcase
            write_digit_map(map);
            case (p)
                0: idle_mode = IDLE_NONE;
                1: idle_mode = IDLE_SENDER;
                2: idle_mode = IDLE_RECEIVER;
                default: idle_mode = IDLE_BOTH;
            endcase

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                pick = $urandom_range(0, 19);
                if (sent == 0)
                    set_len = MAX_ITEMS - 1 + $urandom_range(0, 3);
                else if (pick == 0)
                    set_len = MAX_ITEMS + $urandom_range(0, 3);
                else if (pick < 4)
                    set_len = $urandom_range(11, 40);
                else
                    set_len = $urandom_range(1, 10);
                for (k = 0; k < set_len; k++) begin
                    // short numbers repeat keys often, which exercises stability
                    case ($urandom_range(0, 9))
                        0:       value = '0;
                        1:       value = VAL_W'($urandom_range(1000000000, 1073741823));
                        2:       value = VAL_W'($urandom);
                        3, 4, 5: value = VAL_W'($urandom_range(0, 99));
                        6, 7:    value = VAL_W'($urandom_range(0, 99999));
                        default: value = VAL_W'($urandom_range(0, 999999999));
                    endcase
                    send_item(value, k == set_len - 1);
                end
                sent += set_len;
            end
        end

        drain_and_settle();
        if (runs.errors == 0 && runs.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
sv/drks_pkg.sv
sv/drks_key_stage.sv
sv/drks_cell.sv
sv/digit_remap_key_sorter.sv
bench/testbench.sv
